@@ rtl/core/cmfb_pkg.sv @@
// cmfb_pkg: types, constants and byte helpers for the motion command frame builder
// used by cmfb_prep, cmfb_serial and motion_command_frame_builder_unit

package cmfb_pkg;

    localparam int FRAME_LEN   = 32;
    localparam int NUM_VALS    = 7;
    localparam int VAL_W       = 24;
    localparam int POS_W       = 5;

    localparam logic [7:0]  HEADER_BYTE  = 8'h09;
    localparam logic [7:0]  KIND_POWER   = 8'h0A;
    localparam logic [7:0]  KIND_RUN     = 8'h0B;
    localparam logic [7:0]  TRAILER_BYTE = 8'h10;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;

    localparam logic [POS_W-1:0] POS_CRC_HI = 5'd29;
    localparam logic [POS_W-1:0] POS_CRC_LO = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST   = 5'd31;

    localparam logic CMD_POWER = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    typedef struct packed {
        logic                    command;
        logic        [VAL_W-1:0] pulse_width;
        logic        [VAL_W-1:0] amplitude;
        logic        [VAL_W-1:0] pulse_rate;
        logic signed [VAL_W-1:0] x_shown;
        logic signed [VAL_W-1:0] x_target;
        logic signed [VAL_W-1:0] y_shown;
        logic signed [VAL_W-1:0] y_target;
        logic signed [VAL_W-1:0] z_shown;
        logic signed [VAL_W-1:0] z_target;
        logic signed [VAL_W-1:0] pzt_shown;
        logic signed [VAL_W-1:0] pzt_target;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             frame_kind;
        logic             last_byte;
    } res_t;

    typedef struct packed {
        logic                             kind;
        logic [2:0]                       signs;
        logic [NUM_VALS-1:0][VAL_W-1:0]   vals;
    } frame_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // payload bytes 0..28 and the trailer; crc bytes are filled by the caller
    function automatic logic [7:0] frame_byte_sel(input frame_t f, input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (pos)
            5'd0:  b = HEADER_BYTE;
            5'd1:  b = f.kind ? KIND_RUN : KIND_POWER;
            5'd2:  b = f.vals[0][23:16];
            5'd3:  b = f.vals[0][15:8];
            5'd4:  b = f.vals[0][7:0];
            5'd5:  b = f.vals[1][23:16];
            5'd6:  b = f.vals[1][15:8];
            5'd7:  b = f.vals[1][7:0];
            5'd8:  b = f.vals[2][23:16];
            5'd9:  b = f.vals[2][15:8];
            5'd10: b = f.vals[2][7:0];
            5'd11: b = f.vals[3][23:16];
            5'd12: b = f.vals[3][15:8];
            5'd13: b = f.vals[3][7:0];
            5'd14: b = f.vals[4][23:16];
            5'd15: b = f.vals[4][15:8];
            5'd16: b = f.vals[4][7:0];
            5'd17: b = f.vals[5][23:16];
            5'd18: b = f.vals[5][15:8];
            5'd19: b = f.vals[5][7:0];
            5'd20: b = f.vals[6][23:16];
            5'd21: b = f.vals[6][15:8];
            5'd22: b = f.vals[6][7:0];
            5'd23: b = {5'b00000, f.signs};
            5'd31: b = TRAILER_BYTE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/cmfb_prep.sv @@
// cmfb_prep: turns an accepted command into the held frame values and sign bits
// depends on cmfb_pkg

module cmfb_prep
    import cmfb_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  cmd_t   cmd,
    output frame_t frame
);

    frame_t frame_reg;
    frame_t frame_next;

    logic [VAL_W-1:0] mag_x, mag_y, mag_z, mag_p;
    logic             neg_x, neg_y, neg_z;

    function automatic logic [VAL_W:0] diff_mag(input logic [VAL_W-1:0] s,
                                                input logic [VAL_W-1:0] t);
        logic [VAL_W:0] d;
        logic [VAL_W:0] m;
        d = {s[VAL_W-1], s} - {t[VAL_W-1], t};
        m = d[VAL_W] ? (~d + 1'b1) : d;
        return {d[VAL_W], m[VAL_W-1:0]};
    endfunction

    always_comb
    begin
        {neg_x, mag_x} = diff_mag(cmd.x_shown, cmd.x_target);
        {neg_y, mag_y} = diff_mag(cmd.y_shown, cmd.y_target);
        {neg_z, mag_z} = diff_mag(cmd.z_shown, cmd.z_target);
        mag_p          = VAL_W'(diff_mag(cmd.pzt_shown, cmd.pzt_target));
    end

    always_comb
    begin
        frame_next      = '0;
        frame_next.kind = cmd.command;
        if (cmd.command == CMD_RUN)
        begin
            frame_next.signs   = {neg_z, neg_y, neg_x};
            frame_next.vals[0] = mag_x;
            frame_next.vals[1] = mag_y;
            frame_next.vals[2] = mag_z;
            frame_next.vals[3] = mag_p;
            frame_next.vals[4] = cmd.x_target;
            frame_next.vals[5] = cmd.y_target;
            frame_next.vals[6] = cmd.z_target;
        end
        else
        begin
            frame_next.vals[0] = cmd.pulse_width;
            frame_next.vals[1] = cmd.amplitude;
            frame_next.vals[2] = cmd.pulse_rate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

@@ rtl/core/cmfb_serial.sv @@
// cmfb_serial: byte counter, running crc and result register for one frame
// depends on cmfb_pkg

module cmfb_serial
    import cmfb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  frame_t frame,
    output logic   busy,
    output logic   strobe,
    output res_t   result
);

    logic             active_reg;
    logic             active_next;
    logic [POS_W-1:0] cnt_reg;
    logic [POS_W-1:0] cnt_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic             strobe_reg;
    res_t             result_reg;
    res_t             result_next;
    logic [7:0]       cur_byte;

    always_comb
    begin
        if (cnt_reg == POS_CRC_HI)
        begin
            cur_byte = crc_reg[15:8];
        end
        else if (cnt_reg == POS_CRC_LO)
        begin
            cur_byte = crc_reg[7:0];
        end
        else
        begin
            cur_byte = frame_byte_sel(frame, cnt_reg);
        end
    end

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        crc_next    = crc_reg;
        if (active_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg < POS_CRC_HI)
            begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end
            if (cnt_reg == POS_LAST)
            begin
                active_next = 1'b0;
            end
        end
        if (load)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            crc_next    = CRC_INIT;
        end
    end

    always_comb
    begin
        result_next.frame_byte    = cur_byte;
        result_next.byte_position = cnt_reg;
        result_next.frame_kind    = frame.kind;
        result_next.last_byte     = (cnt_reg == POS_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            crc_reg    <= CRC_INIT;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            crc_reg    <= crc_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            result_reg <= result_next;
        end
    end

    // free on the trailer byte so the next transaction follows without a gap
    assign busy   = active_reg && (cnt_reg != POS_LAST);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/motion_command_frame_builder_unit.sv @@
// motion_command_frame_builder_unit: top level of the 32-byte crc-16 command framer
// depends on cmfb_pkg, cmfb_prep and cmfb_serial
//
//   channel   signals              direction  transfer
//   command   start, busy, cmd     in         start high while busy low
//   frame     strobe, result       out        strobe high with each byte
//
// each transaction yields 32 result bytes, one per cycle, set by the byte counter
// and the byte-wide crc update; the first byte passes the counter and the result
// register; busy falls during the trailer byte, so commands run back to back
// reset clears the counter and strobe and sets the crc to its initial value; the block
// comes out of reset idle; the receiver cannot stall; every strobed byte is taken in its cycle

module motion_command_frame_builder_unit
    import cmfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic strobe,
    output res_t result
);

    logic   load;
    frame_t frame;

    assign load = start && !busy;

    cmfb_prep u_prep
    (
        .clk   (clk),
        .load  (load),
        .cmd   (cmd),
        .frame (frame)
    );

    cmfb_serial u_serial
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .frame  (frame),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

endmodule

@@ sim/tb_motion_command_frame_builder_unit.sv @@
// tb_motion_command_frame_builder_unit: self-checking bench for the crc-16 command framer
// predicts all 32 frame bytes per command and checks every strobed byte in order
// depends on cmfb_pkg and motion_command_frame_builder_unit
`timescale 1ns / 1ps

module tb_motion_command_frame_builder_unit;
    import cmfb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic strobe;
    res_t result;

    res_t frame_bytes_due[$];
    int mismatch_count = 0;
    int sender_idle_pct = 0;

    motion_command_frame_builder_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        logic feedback;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = r[15] ^ data[i];
            r = {r[14:0], 1'b0};
            if (feedback)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [23:0] diff_magnitude(input logic signed [23:0] shown,
                                                   input logic signed [23:0] target,
                                                   output logic negative);
        int d;
        d = shown - target;
        negative = (d < 0);
        if (negative)
        begin
            d = -d;
        end
        return d[23:0];
    endfunction

    function automatic void predict_frame(input cmd_t c);
        logic [7:0] bytes [FRAME_LEN];
        logic [23:0] vals [NUM_VALS];
        logic [2:0] signs;
        logic neg;
        logic [15:0] crc;
        int nvals;
        res_t r;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            bytes[i] = 8'h00;
        end
        signs = 3'b000;
        bytes[0] = HEADER_BYTE;
        if (c.command == CMD_RUN)
        begin
            bytes[1] = KIND_RUN;
            vals[0] = diff_magnitude(c.x_shown, c.x_target, neg);
            signs[0] = neg;
            vals[1] = diff_magnitude(c.y_shown, c.y_target, neg);
            signs[1] = neg;
            vals[2] = diff_magnitude(c.z_shown, c.z_target, neg);
            signs[2] = neg;
            // pzt sign is dropped
            vals[3] = diff_magnitude(c.pzt_shown, c.pzt_target, neg);
            vals[4] = c.x_target;
            vals[5] = c.y_target;
            vals[6] = c.z_target;
            nvals = 7;
            bytes[23] = {5'b00000, signs};
        end
        else
        begin
            bytes[1] = KIND_POWER;
            vals[0] = c.pulse_width;
            vals[1] = c.amplitude;
            vals[2] = c.pulse_rate;
            nvals = 3;
        end
        for (int i = 0; i < nvals; i++)
        begin
            bytes[2 + 3 * i] = vals[i][23:16];
            bytes[3 + 3 * i] = vals[i][15:8];
            bytes[4 + 3 * i] = vals[i][7:0];
        end
        crc = CRC_INIT;
        for (int i = 0; i < POS_CRC_HI; i++)
        begin
            crc = crc16_ccitt_next(crc, bytes[i]);
        end
        bytes[POS_CRC_HI] = crc[15:8];
        bytes[POS_CRC_LO] = crc[7:0];
        bytes[POS_LAST] = TRAILER_BYTE;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            r.frame_byte = bytes[i];
            r.byte_position = POS_W'(i);
            r.frame_kind = c.command;
            r.last_byte = (i == FRAME_LEN - 1);
            frame_bytes_due.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input logic [7:0] expected, input logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // result check first, then prediction for a transaction taken at the same edge
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("frame_byte: expected none, got 0x%0h at position %0d",
                           result.frame_byte, result.byte_position);
                    mismatch_count++;
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    check_field("frame_byte", want.frame_byte, result.frame_byte);
                    check_field("byte_position", 8'(want.byte_position), 8'(result.byte_position));
                    check_field("frame_kind", 8'(want.frame_kind), 8'(result.frame_kind));
                    check_field("last_byte", 8'(want.last_byte), 8'(result.last_byte));
                end
            end
            if (start && !busy)
            begin
                predict_frame(cmd);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || strobe || (start && !busy))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("motion_command_frame_builder_unit verification failed");
        $finish;
    end

    // start stays high after acceptance so back-to-back transactions need no low cycle
    task automatic send_command(input cmd_t c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic wait_drained();
        while (frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic cmd_t power_command(input logic [23:0] pw, input logic [23:0] amp,
                                           input logic [23:0] rate);
        cmd_t c;
        c = '0;
        c.command = CMD_POWER;
        c.pulse_width = pw;
        c.amplitude = amp;
        c.pulse_rate = rate;
        return c;
    endfunction

    function automatic cmd_t run_command(input logic [23:0] xs, input logic [23:0] xt,
                                         input logic [23:0] ys, input logic [23:0] yt,
                                         input logic [23:0] zs, input logic [23:0] zt,
                                         input logic [23:0] ps, input logic [23:0] pt);
        cmd_t c;
        c = '0;
        c.command = CMD_RUN;
        c.x_shown = xs;
        c.x_target = xt;
        c.y_shown = ys;
        c.y_target = yt;
        c.z_shown = zs;
        c.z_target = zt;
        c.pzt_shown = ps;
        c.pzt_target = pt;
        return c;
    endfunction

    function automatic logic [23:0] random_value();
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h800000;
            3: return 24'h7FFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        c.command = $urandom_range(1) ? CMD_RUN : CMD_POWER;
        c.pulse_width = random_value();
        c.amplitude = random_value();
        c.pulse_rate = random_value();
        c.x_shown = random_value();
        c.x_target = random_value();
        c.y_shown = random_value();
        c.y_target = random_value();
        c.z_shown = random_value();
        c.z_target = random_value();
        c.pzt_shown = random_value();
        c.pzt_target = random_value();
        return c;
    endfunction

    task automatic test_power_frames();
        cmd_t c;
        sender_idle_pct = 0;
        send_command(power_command(24'h000000, 24'h000000, 24'h000000));
        send_command(power_command(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_command(power_command(24'hAAAAAA, 24'h555555, 24'h0F0F0F));
        send_command(power_command(24'h800000, 24'h7FFFFF, 24'h000001));
        // run fields must not leak into a power frame
        c = run_command(24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h123456,
                        24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF);
        c.command = CMD_POWER;
        c.pulse_width = 24'h123456;
        send_command(c);
    endtask

    task automatic test_run_frames();
        cmd_t c;
        sender_idle_pct = 0;
        send_command(run_command('0, '0, '0, '0, '0, '0, '0, '0));
        // full-scale differences both ways
        send_command(run_command(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
                                 24'h000001, 24'h000000, 24'h800000, 24'h7FFFFF));
        send_command(run_command(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                                 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
        // negative targets, mixed signs, negative pzt difference
        send_command(run_command(24'h000000, 24'hFFFFFF, 24'hFFFFFE, 24'h000005,
                                 24'h123456, 24'h800000, 24'h000000, 24'h000001));
        send_command(run_command(24'hFFFFF0, 24'hFFFFF8, 24'h000010, 24'hFFFFFF,
                                 24'hFFFFFF, 24'h000001, 24'h800001, 24'h000002));
        // equal shown and target gives zero magnitude and no sign
        send_command(run_command(24'h654321, 24'h654321, 24'h9ABCDE, 24'h9ABCDE,
                                 24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h800000));
        // power fields must not leak into a run frame
        c = run_command(24'h0A0A0A, 24'h050505, 24'hF0F0F0, 24'h0F0F0F,
                        24'h333333, 24'hCCCCCC, 24'h5A5A5A, 24'hA5A5A5);
        c.pulse_width = 24'hFFFFFF;
        c.amplitude = 24'hFFFFFF;
        c.pulse_rate = 24'hFFFFFF;
        send_command(c);
        send_command(power_command(24'h010203, 24'h040506, 24'h070809));
        send_command(c);
    endtask

    task automatic test_drain_pause();
        sender_idle_pct = 0;
        repeat (3) send_command(random_command());
        start <= 1'b0;
        wait_drained();
        repeat (3) send_command(random_command());
    endtask

    task automatic test_random_traffic(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        repeat (count) send_command(random_command());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_frames();
        test_run_frames();
        test_drain_pause();
        test_random_traffic(19, 32);
        test_random_traffic(81, 32);
        test_random_traffic(0, 32);
        start <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("motion_command_frame_builder_unit verification clean");
        end
        else
        begin
            $display("motion_command_frame_builder_unit verification failed");
        end
        $finish;
    end

endmodule
